FILE: hw/rtl/assert_macros.svh
// assertion macros for the scanner core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_AT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/fdfs_pkg.sv
// package of the format directed field scanner: types, codes, helpers
`timescale 1ns / 1ps

package fdfs_pkg;

  localparam int FORMAT_CHARS = 32;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int FMT_WORDS    = 4;
  localparam int POS_W        = 6;
  localparam int CNT_W        = 5;
  localparam int VAL_W        = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_EOF   = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_INT  = 3'd0,
    KIND_CHAR = 3'd1,
    KIND_SBYTE = 3'd2,
    KIND_SEND = 3'd3,
    KIND_DONE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_EOF,
    OP_START
  } op_e;

  typedef enum logic [2:0] {
    STEP_NONE  = 3'd0,
    STEP_WS    = 3'd1,
    STEP_DSKIP = 3'd2,
    STEP_DFIRST = 3'd3,
    STEP_DNUM  = 3'd4,
    STEP_SSKIP = 3'd5,
    STEP_SBODY = 3'd6
  } step_e;

  typedef enum logic [1:0] {
    BS_WAIT,
    BS_RUN,
    BS_FLUSH
  } bstate_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] conversions;
    logic             empty_input;
    logic             last;
  } res_t;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

FILE: hw/rtl/fdfs_if.sv
// valid/ready channel interfaces for input items and result items
`timescale 1ns / 1ps

interface fdfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] in_byte;
  modport source (output valid, mode, in_byte, input ready);
  modport sink (input valid, mode, in_byte, output ready);
endinterface

interface fdfs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic signed [31:0] value;
  logic [4:0]  conversions;
  logic        empty_input;
  logic        last;
  modport source (output valid, kind, value, conversions, empty_input, last, input ready);
  modport sink (input valid, kind, value, conversions, empty_input, last, output ready);
endinterface

FILE: hw/rtl/fdfs_front.sv
// front end: accepts input beats, decodes the mode and queues the items
`timescale 1ns / 1ps

module fdfs_front import fdfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_mode_i,
  input  logic [7:0] in_byte_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  item_t      slot_q [2];
  logic [1:0] fill_q, fill_d;
  logic       rd_q, rd_d;
  logic       wr_q, wr_d;
  logic       take, push, known;
  item_t      item;

  assign in_ready_o = (fill_q != 2'd2);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    known     = 1'b1;
    item.data = in_byte_i;
    item.op   = OP_BYTE;
    unique case (in_mode_i)
      MODE_BYTE:  item.op = OP_BYTE;
      MODE_EOF:   item.op = OP_EOF;
      MODE_START: item.op = OP_START;
      default:    known = 1'b0;
    endcase
  end

  // mode three beats are taken and dropped here
  assign push = take && known;

  assign q_valid_o = (fill_q != 2'd0);
  assign q_item_o  = slot_q[rd_q];

  always_comb begin
    fill_d = fill_q;
    rd_d   = rd_q;
    wr_d   = wr_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (q_pop_i && q_valid_o) begin
      rd_d = ~rd_q;
    end
    if (push && !(q_pop_i && q_valid_o)) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      rd_q   <= 1'b0;
      wr_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rd_q   <= rd_d;
      wr_q   <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item;
    end
  end

endmodule

FILE: hw/rtl/fdfs_back.sv
// back end: format registers, scan sequencer and result register
`timescale 1ns / 1ps

module fdfs_back import fdfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  output res_t                 out_res_o,
  input  logic                 out_ready_i
);

  logic [CFG_W-1:0] fmt_q [FMT_WORDS];
  logic [POS_W-1:0] flen_q;
  logic [FMT_WORDS*CFG_W-1:0] fmt_vec;

  bstate_e state_q, state_d;
  logic             run_q, run_d;
  logic [POS_W-1:0] pos_q, pos_d;
  step_e            step_q, step_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [7:0]       held_q, held_d;
  logic             hv_q, hv_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seen_q, seen_d;
  logic             eof_q, eof_d;
  logic [1:0]       nres_q, nres_d;
  logic             pend_v_q, pend_v_d;
  res_t             pend_q, pend_d;
  logic             out_v_q, out_v_d;
  res_t             out_q, out_d;

  // one sequencer step
  logic             it_stop, it_emit, it_stall, slot_ok, out_free;
  kind_e            it_kind;
  logic [VAL_W-1:0] it_value;
  logic             it_empty;
  logic [POS_W-1:0] len, pos1;
  logic [7:0]       ch, conv;
  logic             have;
  logic [VAL_W-1:0] acc_x10;

  assign fmt_vec = {fmt_q[3], fmt_q[2], fmt_q[1], fmt_q[0]};
  assign len  = (flen_q > POS_W'(FORMAT_CHARS)) ? POS_W'(FORMAT_CHARS) : flen_q;
  assign pos1 = pos_q + POS_W'(1);
  assign ch   = fmt_vec[pos_q[4:0]*8 +: 8];
  assign conv = (pos1 < len) ? fmt_vec[pos1[4:0]*8 +: 8] : 8'd0;
  assign have = hv_q;
  assign acc_x10 = {acc_q[VAL_W-4:0], 3'b000} + {acc_q[VAL_W-2:0], 1'b0};

  assign out_free = !out_v_q || out_ready_i;
  assign slot_ok  = !pend_v_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FMT_WORDS; i++) fmt_q[i] <= '0;
      flen_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < REG_LENGTH) begin
        fmt_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end else if (cfg_idx_i == REG_LENGTH) begin
        flen_q <= cfg_data_i[POS_W-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_WAIT: begin
        if (q_valid_i) begin
          unique case (q_item_i.op)
            OP_START: state_d = hv_q ? BS_RUN : BS_WAIT;
            OP_BYTE:  state_d = run_q ? BS_RUN : BS_WAIT;
            OP_EOF:   state_d = !run_q ? BS_WAIT : (seen_q ? BS_RUN : BS_FLUSH);
            default:  state_d = BS_WAIT;
          endcase
        end
      end
      BS_RUN: begin
        if (!it_stall && it_stop) state_d = BS_FLUSH;
      end
      BS_FLUSH: begin
        if (!pend_v_q || out_free) state_d = BS_WAIT;
      end
      default: state_d = BS_WAIT;
    endcase
  end

  // sequencer step over the current format element
  always_comb begin
    it_stop  = 1'b0;
    it_emit  = 1'b0;
    it_kind  = KIND_DONE;
    it_value = '0;
    it_empty = 1'b0;
    run_d  = run_q;
    pos_d  = pos_q;
    step_d = step_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    hv_d   = hv_q;
    cnt_d  = cnt_q;
    if (!run_q) begin
      it_stop = 1'b1;
    end else if (step_q == STEP_NONE) begin
      if (pos_q >= len) begin
        it_emit = 1'b1;
      end else if (ch == CH_PCT) begin
        if (conv == CH_D) begin
          acc_d = '0; neg_d = 1'b0; step_d = STEP_DSKIP;
        end else if (conv == CH_S) begin
          step_d = STEP_SSKIP;
        end else if (conv != CH_C) begin
          it_emit = 1'b1;
        end else if (!have) begin
          if (eof_q) it_emit = 1'b1;
          else it_stop = 1'b1;
        end else begin
          hv_d = 1'b0;
          cnt_d = cnt_q + CNT_W'(1);
          it_emit = 1'b1; it_kind = KIND_CHAR; it_value = VAL_W'(held_q);
          pos_d = pos_q + POS_W'(2);
        end
      end else if (is_ws(ch)) begin
        step_d = STEP_WS;
      end else if (!have) begin
        if (eof_q) it_emit = 1'b1;
        else it_stop = 1'b1;
      end else if (held_q != ch) begin
        it_emit = 1'b1;
      end else begin
        hv_d = 1'b0;
        pos_d = pos1;
      end
    end else if (step_q == STEP_DNUM || step_q == STEP_SBODY) begin
      if (!have && !eof_q) begin
        it_stop = 1'b1;
      end else if (step_q == STEP_DNUM) begin
        if (have && is_digit(held_q)) begin
          acc_d = acc_x10 + VAL_W'(held_q - CH_ZERO);
          hv_d = 1'b0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
          it_emit = 1'b1; it_kind = KIND_INT;
          it_value = neg_q ? (VAL_W'(0) - acc_q) : acc_q;
          pos_d = pos_q + POS_W'(2);
          step_d = STEP_NONE;
        end
      end else begin
        if (have && !is_ws(held_q)) begin
          it_emit = 1'b1; it_kind = KIND_SBYTE; it_value = VAL_W'(held_q);
          hv_d = 1'b0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
          it_emit = 1'b1; it_kind = KIND_SEND;
          pos_d = pos_q + POS_W'(2);
          step_d = STEP_NONE;
        end
      end
    end else if (!have) begin
      if (eof_q) it_emit = 1'b1;
      else it_stop = 1'b1;
    end else begin
      unique case (step_q)
        STEP_WS: begin
          if (is_ws(held_q)) hv_d = 1'b0;
          else begin pos_d = pos1; step_d = STEP_NONE; end
        end
        STEP_DSKIP: begin
          if (is_ws(held_q)) hv_d = 1'b0;
          else begin
            if (held_q == CH_PLUS || held_q == CH_MINUS) begin
              neg_d = (held_q == CH_MINUS);
              hv_d = 1'b0;
            end
            step_d = STEP_DFIRST;
          end
        end
        STEP_DFIRST: begin
          if (!is_digit(held_q)) it_emit = 1'b1;
          else begin
            acc_d = VAL_W'(held_q - CH_ZERO);
            hv_d = 1'b0;
            step_d = STEP_DNUM;
          end
        end
        STEP_SSKIP: begin
          if (is_ws(held_q)) hv_d = 1'b0;
          else step_d = STEP_SBODY;
        end
        default: it_emit = 1'b1;
      endcase
    end
    // done result closes the scan
    if (run_q && it_emit && it_kind == KIND_DONE) begin
      it_stop = 1'b1;
      run_d = 1'b0;
      step_d = STEP_NONE;
    end
  end

  assign it_stall = it_emit && !slot_ok;

  // datapath and outputs
  always_comb begin
    q_pop_o  = 1'b0;
    held_d   = held_q;
    seen_d   = seen_q;
    eof_d    = eof_q;
    nres_d   = nres_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !out_ready_i;
    unique case (state_q)
      BS_WAIT: begin
        q_pop_o = q_valid_i;
        nres_d  = 2'd0;
        eof_d   = 1'b0;
        if (q_valid_i && q_item_i.op == OP_EOF && run_q) begin
          eof_d = 1'b1;
          if (!seen_q) begin
            pend_v_d = 1'b1;
            nres_d   = 2'd1;
          end
        end
      end
      BS_RUN: begin
        if (!it_stall && it_emit && nres_q != 2'd3) begin
          nres_d = nres_q + 2'd1;
          if (pend_v_q) begin
            out_d = pend_q; out_v_d = 1'b1;
          end
          pend_v_d = 1'b1;
          pend_d.kind = it_kind;
          pend_d.value = it_value;
          pend_d.conversions = cnt_d;
          pend_d.empty_input = it_empty;
          pend_d.last = 1'b0;
        end
      end
      BS_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_d = pend_q; out_d.last = 1'b1; out_v_d = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BS_WAIT;
      run_q    <= 1'b0;
      pos_q    <= '0;
      step_q   <= STEP_NONE;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      held_q   <= '0;
      hv_q     <= 1'b0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      eof_q    <= 1'b0;
      nres_q   <= 2'd0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      eof_q    <= eof_d;
      nres_q   <= nres_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (state_q == BS_WAIT && q_valid_i) begin
        unique case (q_item_i.op)
          OP_START: begin
            run_q <= 1'b1; pos_q <= '0; step_q <= STEP_NONE;
            acc_q <= '0; neg_q <= 1'b0; cnt_q <= '0; seen_q <= hv_q;
          end
          OP_BYTE: begin
            if (run_q) begin
              if (!hv_q) begin
                held_q <= q_item_i.data; hv_q <= 1'b1;
              end
              seen_q <= 1'b1;
            end
          end
          OP_EOF: begin
            if (run_q && !seen_q) begin
              run_q <= 1'b0; step_q <= STEP_NONE;
            end
          end
          default: ;
        endcase
      end else if (state_q == BS_RUN && !it_stall) begin
        run_q  <= run_d;
        pos_q  <= pos_d;
        step_q <= step_d;
        acc_q  <= acc_d;
        neg_q  <= neg_d;
        hv_q   <= hv_d;
        cnt_q  <= cnt_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (state_q == BS_WAIT && q_valid_i && q_item_i.op == OP_EOF && run_q && !seen_q) begin
      // empty input: done without any byte
      pend_q.kind        <= KIND_DONE;
      pend_q.value       <= '0;
      pend_q.conversions <= cnt_q;
      pend_q.empty_input <= 1'b1;
      pend_q.last        <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

endmodule

FILE: hw/rtl/format_directed_field_scanner_core.sv
// top level of the format directed field scanner
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Matches a byte stream against a stored format of up to 32 characters (scanf
// subset with %c, %d and %s). Write the four format words and the length while
// idle, send mode 2 to start a scan, then bytes (mode 0) and end of input
// (mode 1). Each input beat lands in a two-entry queue; the sequencer then
// steps once per cycle through format elements, holding a step that emits a
// result while the result slot is full. The back end takes no new beat until
// the last result of the current one has been flushed. Up to three results
// follow one beat, the final one flagged last; a scan ends with a done result
// that carries the conversion count.
module format_directed_field_scanner_core import fdfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fdfs_in_if.sink              in_bus,
  fdfs_out_if.source           out_bus,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic  q_valid, q_pop, out_valid;
  item_t q_item;
  res_t  out_res;

  fdfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_bus.valid),
    .in_ready_o (in_bus.ready),
    .in_mode_i  (in_bus.mode),
    .in_byte_i  (in_bus.in_byte),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  fdfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_res_o   (out_res),
    .out_ready_i (out_bus.ready)
  );

  assign out_bus.valid       = out_valid;
  assign out_bus.kind        = out_res.kind;
  assign out_bus.value       = out_res.value;
  assign out_bus.conversions = out_res.conversions;
  assign out_bus.empty_input = out_res.empty_input;
  assign out_bus.last        = out_res.last;

  `ASSERT_IMPL(a_done_last, out_bus.valid && out_bus.kind == KIND_DONE, out_bus.last)
  `ASSERT_IMPL(a_empty_done, out_bus.valid && out_bus.empty_input, out_bus.kind == KIND_DONE)
  `ASSERT_AT(a_conv_range, !out_bus.valid || out_bus.conversions <= 5'd16)
  `ASSERT_NEXT(a_out_hold, out_bus.valid && !out_bus.ready, out_bus.valid)

endmodule
